FILE: design/skc_pkg.sv
`default_nettype none

package skc_pkg;

  localparam int unsigned PIXEL_BITS_DEF = 8;
  localparam int unsigned WINDOW_TAPS    = 9;
  localparam int unsigned KSEL_BITS      = 4;

  // kernel select codes
  localparam logic [KSEL_BITS-1:0] KSEL_BOX     = 4'd0;
  localparam logic [KSEL_BITS-1:0] KSEL_LP_TEN  = 4'd1;
  localparam logic [KSEL_BITS-1:0] KSEL_LP_16   = 4'd2;
  localparam logic [KSEL_BITS-1:0] KSEL_SHARP1  = 4'd3;
  localparam logic [KSEL_BITS-1:0] KSEL_SHARP2  = 4'd4;
  localparam logic [KSEL_BITS-1:0] KSEL_SHARP3  = 4'd5;
  localparam logic [KSEL_BITS-1:0] KSEL_LAP1    = 4'd6;
  localparam logic [KSEL_BITS-1:0] KSEL_LAP2    = 4'd7;
  localparam logic [KSEL_BITS-1:0] KSEL_LAP3    = 4'd8;

  // how the weighted sum is scaled back to a pixel
  typedef enum logic [1:0] {
    DIV_UNIT = 2'd0,
    DIV_NINE = 2'd1,
    DIV_TEN  = 2'd2,
    DIV_16   = 2'd3
  } div_cls_t;

endpackage

`default_nettype wire

FILE: design/skc_round_clamp.sv
`default_nettype none

module skc_round_clamp
  import skc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [PIXEL_BITS+4:0] in_sum,
  input  wire div_cls_t                     in_cls,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [PIXEL_BITS-1:0]             out_pixel
);

  localparam int unsigned SW = PIXEL_BITS + 5;
  localparam int unsigned N  = PIXEL_BITS + 4;
  localparam int unsigned K  = N + 4;
  localparam int unsigned MW = N + 1;
  localparam logic [MW-1:0] M_NINE = MW'(((2 ** K) + 8) / 9);
  localparam logic [MW-1:0] M_TEN  = MW'(((2 ** K) + 9) / 10);
  localparam logic [N-1:0]  PMAX   = N'((2 ** PIXEL_BITS) - 1);

  logic            v3, v4, v5;
  logic            rdy3, rdy4, rdy5;
  logic [N-1:0]    x3, x4;
  logic [MW-1:0]   m3;
  logic            zero3, zero4;
  div_cls_t        cls3, cls4;
  logic [N+MW-1:0] prod4;
  logic [N-1:0]    bias;
  logic [N-1:0]    q;
  logic [PIXEL_BITS-1:0] pix5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  // half-up rounding bias for floor((s + d/2) / d)
  always_comb begin
    case (in_cls)
      DIV_NINE: bias = N'(4);
      DIV_TEN:  bias = N'(5);
      DIV_16:   bias = N'(8);
      default:  bias = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      zero3 <= in_sum[SW-1] || (in_sum == '0);
      x3    <= in_sum[N-1:0] + bias;
      m3    <= (in_cls == DIV_TEN) ? M_TEN : M_NINE;
      cls3  <= in_cls;
    end
    if (rdy4) begin
      // reciprocal multiply, exact for every x below 2^N
      prod4 <= (N+MW)'(x3) * (N+MW)'(m3);
      x4    <= x3;
      zero4 <= zero3;
      cls4  <= cls3;
    end
    if (rdy5) begin
      pix5 <= zero4 ? '0 : ((q > PMAX) ? PMAX[PIXEL_BITS-1:0] : q[PIXEL_BITS-1:0]);
    end
  end

  always_comb begin
    case (cls4)
      DIV_NINE, DIV_TEN: q = N'(prod4[N+MW-1:K]);
      DIV_16:            q = x4 >> 4;
      default:           q = x4;
    endcase
  end

  assign out_valid = v5;
  assign out_pixel = pix5;

endmodule

`default_nettype wire

FILE: design/selectable_kernel_conv3x3.sv
`default_nettype none

// 3x3 convolution with nine selectable fixed kernels (low-pass, sharpen, Laplacian).
// Each input word carries one full window; each output word is one pixel, the
// weighted sum divided by the kernel divisor, rounded half up, clamped to the
// pixel range. The block takes one window per clock unless back-pressure stalls it;
// each accepted window passes through the stages in order: stage 1 forms the corner,
// edge and center sums, stage 2 the kernel sum, stage 3 the sign test and rounding
// bias, stage 4 the reciprocal multiply for divisors 9 and 10, stage 5 the shift and clamp.
// Every stage holds its word under back-pressure and empty stages fill up, so up
// to five windows can be taken while the output waits. kernel_select codes 9 to
// 15 act as code 8; write it only while no windows are in flight.
module selectable_kernel_conv3x3
  import skc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [KSEL_BITS-1:0]   cfg_wr_data,     // kernel_select
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pix_up_left, pix_up, pix_up_right, pix_left, pix_center, pix_right,
  // pix_down_left, pix_down, pix_down_right, then zero fill
  input  wire logic [((WINDOW_TAPS*PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0] m_axis_tdata  // filtered_pixel, then zero fill
);

  localparam int unsigned SW = PIXEL_BITS + 5;
  localparam int unsigned GW = PIXEL_BITS + 2;
  localparam int unsigned OW = ((PIXEL_BITS + 7) / 8) * 8;

  logic [KSEL_BITS-1:0]  kernel_select;
  logic [KSEL_BITS-1:0]  kcode;
  logic [PIXEL_BITS-1:0] pix [WINDOW_TAPS];

  logic                 v1, v2, rdy1, rdy2, tail_ready;
  logic [GW-1:0]        corner1, edge1, center1;
  logic [KSEL_BITS-1:0] code1;
  logic signed [SW-1:0] sum2;
  div_cls_t             cls2;

  logic signed [SW-1:0] c_s, e_s, p_s, c_term, e_term, p_term, sum_next;
  div_cls_t             cls_next;
  logic [PIXEL_BITS-1:0] pixel_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= KSEL_BOX;
    end else if (cfg_wr_en) begin
      kernel_select <= cfg_wr_data;
    end
  end

  assign kcode = (kernel_select > KSEL_LAP3) ? KSEL_LAP3 : kernel_select;

  for (genvar i = 0; i < WINDOW_TAPS; i++) begin : g_unpack
    assign pix[i] = s_axis_tdata[i*PIXEL_BITS +: PIXEL_BITS];
  end

  assign rdy2          = !v2 || tail_ready;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
    end
  end

  // all nine kernels are symmetric: corners, edges and center share weights
  always_ff @(posedge clk) begin
    if (rdy1) begin
      corner1 <= GW'(pix[0]) + GW'(pix[2]) + GW'(pix[6]) + GW'(pix[8]);
      edge1   <= GW'(pix[1]) + GW'(pix[3]) + GW'(pix[5]) + GW'(pix[7]);
      center1 <= GW'(pix[4]);
      code1   <= kcode;
    end
    if (rdy2) begin
      sum2 <= sum_next;
      cls2 <= cls_next;
    end
  end

  always_comb begin
    c_s = signed'(SW'(corner1));
    e_s = signed'(SW'(edge1));
    p_s = signed'(SW'(center1));
    case (code1)
      KSEL_BOX: begin
        c_term = c_s;  e_term = e_s;        p_term = p_s;
        cls_next = DIV_NINE;
      end
      KSEL_LP_TEN: begin
        c_term = c_s;  e_term = e_s;        p_term = p_s <<< 1;
        cls_next = DIV_TEN;
      end
      KSEL_LP_16: begin
        c_term = c_s;  e_term = e_s <<< 1;  p_term = p_s <<< 2;
        cls_next = DIV_16;
      end
      KSEL_SHARP1: begin
        c_term = '0;   e_term = -e_s;       p_term = (p_s <<< 2) + p_s;
        cls_next = DIV_UNIT;
      end
      KSEL_SHARP2: begin
        c_term = -c_s; e_term = -e_s;       p_term = (p_s <<< 3) + p_s;
        cls_next = DIV_UNIT;
      end
      KSEL_SHARP3: begin
        c_term = c_s;  e_term = -(e_s <<< 1); p_term = (p_s <<< 2) + p_s;
        cls_next = DIV_UNIT;
      end
      KSEL_LAP1: begin
        c_term = '0;   e_term = -e_s;       p_term = p_s <<< 2;
        cls_next = DIV_UNIT;
      end
      KSEL_LAP2: begin
        c_term = -c_s; e_term = -e_s;       p_term = p_s <<< 3;
        cls_next = DIV_UNIT;
      end
      default: begin
        c_term = c_s;  e_term = -(e_s <<< 1); p_term = p_s <<< 2;
        cls_next = DIV_UNIT;
      end
    endcase
    sum_next = c_term + e_term + p_term;
  end

  skc_round_clamp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (tail_ready),
    .in_sum    (sum2),
    .in_cls    (cls2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pixel (pixel_out)
  );

  assign m_axis_tdata = OW'(pixel_out);

endmodule

`default_nettype wire

FILE: design/skc_checker.sv
`default_nettype none

module skc_checker
  import skc_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [((PIXEL_BITS+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned DEPTH = 5;

  logic [2:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 3'd0)
    else $error("output word without a matching input word");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(DEPTH))
    else $error("more words in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd0 |-> s_axis_tready)
    else $error("empty pipeline refuses input");

endmodule

bind selectable_kernel_conv3x3 skc_checker #(.PIXEL_BITS(PIXEL_BITS)) u_skc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
